FILE: rtl/csvtok_pkg.sv
package csvtok_pkg;

	typedef logic [7:0] byte_t;
	typedef logic [7:0] cfg_index_t;

	localparam cfg_index_t CFG_DELIMITER = 8'd0;
	localparam cfg_index_t CFG_QUOTE     = 8'd1;

	localparam byte_t DELIMITER_RESET = 8'd44;
	localparam byte_t QUOTE_RESET     = 8'd34;
	localparam byte_t CHAR_LF         = 8'd10;
	localparam byte_t CHAR_CR         = 8'd13;

	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_EOI  = 1'b1;

	typedef enum logic [1:0] {
		WHAT_BYTE        = 2'd0,
		WHAT_FIELD_END   = 2'd1,
		WHAT_RECORD_END  = 2'd2,
		WHAT_QUOTE_ERROR = 2'd3
	} what_t;

	// classified input item, front to back
	typedef struct packed {
		logic  kind;
		byte_t data_byte;
		logic  is_quote;
		logic  is_delim;
		logic  is_lf;
		logic  is_cr;
	} item_t;

	typedef struct packed {
		logic in_quotes;
		logic quote_pending;
		logic cr_pending;
		logic field_has_bytes;
		logic record_has_fields;
	} parse_state_t;

endpackage

FILE: rtl/csvtok_front.sv
module csvtok_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [7:0]             s_tdata,   // [7:0] data_byte
	input  logic [0:0]             s_tuser,   // [0] kind
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  csvtok_pkg::cfg_index_t cfg_index,
	input  csvtok_pkg::byte_t      cfg_data,
	input  logic                   push_ready,
	output logic                   push_valid,
	output csvtok_pkg::item_t      push_item
);
	import csvtok_pkg::*;

	byte_t delimiter_q;
	byte_t quote_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delimiter_q <= DELIMITER_RESET;
			quote_q     <= QUOTE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_DELIMITER: delimiter_q <= cfg_data;
				CFG_QUOTE:     quote_q     <= cfg_data;
				default:       ;
			endcase
		end
	end

	assign s_tready   = push_ready;
	assign push_valid = s_tvalid;

	always_comb begin
		push_item.kind      = s_tuser[0];
		push_item.data_byte = s_tdata;
		push_item.is_quote  = (s_tdata == quote_q);
		push_item.is_delim  = (s_tdata == delimiter_q);
		push_item.is_lf     = (s_tdata == CHAR_LF);
		push_item.is_cr     = (s_tdata == CHAR_CR);
	end

endmodule

FILE: rtl/csvtok_fifo.sv
module csvtok_fifo #(
	parameter int DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  csvtok_pkg::item_t push_item,
	output logic              pop_valid,
	input  logic              pop_ready,
	output csvtok_pkg::item_t pop_item
);
	import csvtok_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	item_t         mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("fifo count above depth");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("fifo count missed a push");

	a_ptr_sync: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("fifo empty with pointers apart");

endmodule

FILE: rtl/csvtok_back.sv
module csvtok_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pop_valid,
	output logic              pop_ready,
	input  csvtok_pkg::item_t pop_item,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,   // [7:0] out_byte
	output logic [1:0]        m_tuser    // [1:0] what
);
	import csvtok_pkg::*;

	parse_state_t st_q;
	parse_state_t st_d;
	logic         m_tvalid_q;
	what_t        what_q;
	byte_t        byte_q;
	logic         emit_d;
	what_t        what_d;
	byte_t        byte_d;
	logic         do_pop;

	assign pop_ready = !m_tvalid_q || m_tready;
	assign do_pop    = pop_valid && pop_ready;

	always_comb begin
		logic done;
		st_d   = st_q;
		emit_d = 1'b0;
		what_d = WHAT_BYTE;
		byte_d = '0;
		done   = 1'b0;
		if (pop_item.kind == KIND_EOI) begin
			if (st_d.quote_pending) begin
				st_d.quote_pending = 1'b0;
				st_d.in_quotes     = 1'b0;
			end
			st_d.cr_pending = 1'b0;
			if (st_d.in_quotes) begin
				st_d   = '0;
				emit_d = 1'b1;
				what_d = WHAT_QUOTE_ERROR;
			end else if (st_d.field_has_bytes || st_d.record_has_fields) begin
				st_d   = '0;
				emit_d = 1'b1;
				what_d = WHAT_RECORD_END;
			end
		end else begin
			if (st_d.cr_pending) begin
				st_d.cr_pending = 1'b0;
				if (pop_item.is_lf) begin
					done = 1'b1;
				end
			end
			if (!done && st_d.quote_pending) begin
				st_d.quote_pending = 1'b0;
				if (pop_item.is_quote) begin
					// doubled quote: literal quote byte
					st_d.field_has_bytes = 1'b1;
					emit_d = 1'b1;
					byte_d = pop_item.data_byte;
					done   = 1'b1;
				end else begin
					st_d.in_quotes = 1'b0;
				end
			end
			if (!done) begin
				if (pop_item.is_quote) begin
					if (st_d.in_quotes) begin
						st_d.quote_pending = 1'b1;
					end else begin
						st_d.in_quotes = 1'b1;
					end
				end else if (!st_d.in_quotes && pop_item.is_delim) begin
					st_d.field_has_bytes   = 1'b0;
					st_d.record_has_fields = 1'b1;
					emit_d = 1'b1;
					what_d = WHAT_FIELD_END;
				end else if (!st_d.in_quotes && (pop_item.is_lf || pop_item.is_cr)) begin
					st_d.cr_pending        = pop_item.is_cr;
					st_d.field_has_bytes   = 1'b0;
					st_d.record_has_fields = 1'b0;
					emit_d = 1'b1;
					what_d = WHAT_RECORD_END;
				end else begin
					st_d.field_has_bytes = 1'b1;
					emit_d = 1'b1;
					byte_d = pop_item.data_byte;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (do_pop) begin
				st_q <= st_d;
			end
			if (pop_ready) begin
				m_tvalid_q <= do_pop && emit_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_pop && emit_d) begin
			what_q <= what_d;
			byte_q <= byte_d;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = byte_q;
	assign m_tuser  = what_q;

	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && (what_q != WHAT_BYTE)) |-> (byte_q == '0))
		else $error("nonzero byte on a marker result");

	a_pending_in_quotes: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.quote_pending |-> st_q.in_quotes)
		else $error("quote pending outside quotes");

	a_eoi_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && (pop_item.kind == KIND_EOI)) |=> (st_q == '0))
		else $error("state not clear after end of input");

	a_no_pop_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && !m_tready) |-> !do_pop)
		else $error("item taken while result stalled");

endmodule

FILE: rtl/csv_record_tokenizer.sv
// channel  | direction | handshake            | payload
// s_*      | in        | s_tvalid / s_tready  | tdata[7:0] data_byte, tuser[0] kind
// m_*      | out       | m_tvalid / m_tready  | tdata[7:0] out_byte, tuser[1:0] what
// cfg_*    | in        | cfg_valid/cfg_ready  | cfg_index (0 delimiter, 1 quote), cfg_data
//
// One byte per cycle if the output is not stalled; bytes are queued, results registered.
// Front compares each byte against the configured characters and queues it (FIFO_DEPTH);
// back updates parse flags and loads the output register, one queued item per cycle.
// Reset clears parse flags and queue; delimiter and quote return to comma and double quote.
// An output stall holds the back; the front keeps taking bytes until the queue is full.
module csv_record_tokenizer #(
	parameter int FIFO_DEPTH = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [7:0]             s_tdata,   // [7:0] data_byte
	input  logic [0:0]             s_tuser,   // [0] kind
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [7:0]             m_tdata,   // [7:0] out_byte
	output logic [1:0]             m_tuser,   // [1:0] what
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  csvtok_pkg::cfg_index_t cfg_index,
	input  csvtok_pkg::byte_t      cfg_data
);
	import csvtok_pkg::*;

	logic  push_valid;
	logic  push_ready;
	item_t push_item;
	logic  pop_valid;
	logic  pop_ready;
	item_t pop_item;

	csvtok_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.push_ready (push_ready),
		.push_valid (push_valid),
		.push_item  (push_item)
	);

	csvtok_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	csvtok_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_item  (pop_item),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps

typedef struct {
	csvtok_pkg::what_t what;
	csvtok_pkg::byte_t out_byte;
} csv_token_t;

class csv_scoreboard;
	csvtok_pkg::byte_t delim;
	csvtok_pkg::byte_t quote;
	bit in_quotes;
	bit quote_pending;
	bit cr_pending;
	bit field_has_bytes;
	bit record_has_fields;
	csv_token_t expected_tokens[$];
	int errors;
	int n_inputs;
	int n_results;
	int n_by_what[4];

	function new();
		delim = csvtok_pkg::DELIMITER_RESET;
		quote = csvtok_pkg::QUOTE_RESET;
		clear_parse();
		errors = 0;
		n_inputs = 0;
		n_results = 0;
		foreach (n_by_what[i]) n_by_what[i] = 0;
	endfunction

	function void clear_parse();
		in_quotes = 0;
		quote_pending = 0;
		cr_pending = 0;
		field_has_bytes = 0;
		record_has_fields = 0;
	endfunction

	function void write_reg(csvtok_pkg::cfg_index_t idx, csvtok_pkg::byte_t value);
		if (idx == csvtok_pkg::CFG_DELIMITER) delim = value;
		else if (idx == csvtok_pkg::CFG_QUOTE) quote = value;
	endfunction

	function void push_token(csvtok_pkg::what_t w, csvtok_pkg::byte_t b);
		csv_token_t t;
		t.what = w;
		t.out_byte = (w == csvtok_pkg::WHAT_BYTE) ? b : 8'd0;
		expected_tokens.insert(expected_tokens.size(), t);
	endfunction

	// one transfer on the input side
	function void note_input(logic kind, csvtok_pkg::byte_t c);
		n_inputs++;
		if (kind == csvtok_pkg::KIND_EOI) begin
			if (quote_pending) begin
				quote_pending = 0;
				in_quotes = 0;
			end
			cr_pending = 0;
			if (in_quotes) begin
				clear_parse();
				push_token(csvtok_pkg::WHAT_QUOTE_ERROR, 8'd0);
			end else if (field_has_bytes || record_has_fields) begin
				clear_parse();
				push_token(csvtok_pkg::WHAT_RECORD_END, 8'd0);
			end
			return;
		end
		if (cr_pending) begin
			cr_pending = 0;
			if (c == csvtok_pkg::CHAR_LF) return;
		end
		if (quote_pending) begin
			quote_pending = 0;
			if (c == quote) begin
				field_has_bytes = 1;
				push_token(csvtok_pkg::WHAT_BYTE, c);
				return;
			end
			in_quotes = 0;
		end
		if (c == quote) begin
			if (in_quotes) quote_pending = 1;
			else in_quotes = 1;
			return;
		end
		if (!in_quotes && c == delim) begin
			field_has_bytes = 0;
			record_has_fields = 1;
			push_token(csvtok_pkg::WHAT_FIELD_END, 8'd0);
			return;
		end
		if (!in_quotes && (c == csvtok_pkg::CHAR_LF || c == csvtok_pkg::CHAR_CR)) begin
			cr_pending = (c == csvtok_pkg::CHAR_CR);
			field_has_bytes = 0;
			record_has_fields = 0;
			push_token(csvtok_pkg::WHAT_RECORD_END, 8'd0);
			return;
		end
		field_has_bytes = 1;
		push_token(csvtok_pkg::WHAT_BYTE, c);
	endfunction

	// one transfer on the output side
	function void check_result(logic [1:0] what, csvtok_pkg::byte_t b);
		csv_token_t t;
		n_results++;
		n_by_what[what]++;
		if (expected_tokens.size() == 0) begin
			$error("unexpected result: what %0d, out_byte 0x%02h", what, b);
			errors++;
			return;
		end
		t = expected_tokens.pop_front();
		if (what !== t.what) begin
			$error("what: expected %0d, actual %0d", t.what, what);
			errors++;
		end
		if (b !== t.out_byte) begin
			$error("out_byte: expected 0x%02h, actual 0x%02h", t.out_byte, b);
			errors++;
		end
	endfunction
endclass

module tb;
	import csvtok_pkg::*;

	localparam int DRAIN_CYCLES = 12;
	localparam int STALL_LIMIT  = 2000;
	localparam int BLOCK_ITEMS  = 100;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'd0;
	logic [0:0] s_tuser = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic [1:0] m_tuser;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	cfg_index_t cfg_index = 8'd0;
	byte_t      cfg_data = 8'd0;

	csv_scoreboard sb = new();

	int send_idle = 24;
	int recv_idle = 62;
	int stall_cycles = 0;
	int n_settings = 0;

	csv_record_tokenizer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			stall_cycles = 0;
		end else if (arst_n) begin
			stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("timeout: no transfer for %0d cycles", STALL_LIMIT);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	task automatic send_item(logic kind, byte_t b);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= kind;
		do @(posedge clk); while (!s_tready);
		sb.note_input(kind, b);
	endtask

	task automatic send_str(string s);
		for (int i = 0; i < s.len(); i++) send_item(KIND_DATA, s.getc(i));
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (sb.expected_tokens.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_index_t idx, byte_t value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.write_reg(idx, value);
	endtask

	task automatic apply_setting(byte_t d, byte_t q);
		wait_drained();
		write_reg(CFG_DELIMITER, d);
		write_reg(CFG_QUOTE, q);
		write_reg(cfg_index_t'($urandom_range(255, 2)), byte_t'($urandom_range(255)));
		n_settings++;
	endtask

	function automatic byte_t content_byte(bit quoted);
		byte_t c;
		do c = byte_t'($urandom_range(255));
		while (c == sb.quote || (!quoted && (c == sb.delim || c == CHAR_LF || c == CHAR_CR)));
		return c;
	endfunction

	task automatic send_record();
		int nf;
		int len;
		int term;
		nf = $urandom_range(4, 1);
		for (int f = 0; f < nf; f++) begin
			if (f != 0) send_item(KIND_DATA, sb.delim);
			len = $urandom_range(5);
			if ($urandom_range(1)) begin
				send_item(KIND_DATA, sb.quote);
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(4) == 0) begin
						send_item(KIND_DATA, sb.quote);
						send_item(KIND_DATA, sb.quote);
					end else begin
						send_item(KIND_DATA, content_byte(1'b1));
					end
				end
				send_item(KIND_DATA, sb.quote);
			end else begin
				for (int i = 0; i < len; i++) send_item(KIND_DATA, content_byte(1'b0));
			end
		end
		term = $urandom_range(9);
		if (term < 4) begin
			send_item(KIND_DATA, CHAR_LF);
		end else if (term < 6) begin
			send_item(KIND_DATA, CHAR_CR);
		end else if (term < 9) begin
			send_item(KIND_DATA, CHAR_CR);
			send_item(KIND_DATA, CHAR_LF);
		end else begin
			send_item(KIND_EOI, byte_t'($urandom_range(255)));
		end
	endtask

	task automatic send_noise();
		int r;
		r = $urandom_range(99);
		if (r < 25) send_item(KIND_DATA, sb.quote);
		else if (r < 40) send_item(KIND_DATA, sb.delim);
		else if (r < 50) send_item(KIND_DATA, CHAR_LF);
		else if (r < 60) send_item(KIND_DATA, CHAR_CR);
		else if (r < 66) send_item(KIND_EOI, byte_t'($urandom_range(255)));
		else send_item(KIND_DATA, byte_t'($urandom_range(255)));
	endtask

	byte_t setting_delim[12] = '{8'd44, 8'd9,  8'd0,   8'd255, 8'd59, 8'd10,
	                             8'd44, 8'd13, 8'd124, 8'd0,   8'd44, 8'd34};
	byte_t setting_quote[12] = '{8'd34, 8'd39, 8'd255, 8'd0,   8'd59, 8'd34,
	                             8'd13, 8'd10, 8'd39,  8'd0,   8'd34, 8'd44};

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: defaults
		send_str("a,\"b\"\"c\"\n");
		send_str("\r\n\r");
		send_item(KIND_DATA, 8'h00);
		send_item(KIND_DATA, 8'hFF);
		send_item(KIND_EOI, 8'hA5);
		send_str("x\"y");
		send_item(KIND_EOI, 8'h00);
		send_item(KIND_EOI, 8'hFF);
		send_str("\"\"");
		send_item(KIND_EOI, 8'h5A);
		send_str("z\r");
		send_item(KIND_EOI, 8'h00);

		// sender holds off until all results are back
		wait_drained();

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin send_idle = 24; recv_idle = 62; end
				1: begin send_idle = 62; recv_idle = 24; end
				default: begin send_idle = 0; recv_idle = 0; end
			endcase
			for (int k = 0; k < 4; k++) begin
				int idx;
				int target;
				idx = phase * 4 + k;
				if (idx >= 10) apply_setting(byte_t'($urandom_range(255)), byte_t'($urandom_range(255)));
				else apply_setting(setting_delim[idx], setting_quote[idx]);
				target = sb.n_inputs + BLOCK_ITEMS;
				while (sb.n_inputs < target) begin
					if ($urandom_range(99) < 80) send_record();
					else send_noise();
				end
			end
		end

		wait_drained();
		$display("covered %0d input items across %0d register settings and three idle profiles",
			sb.n_inputs, n_settings);
		$display("checked %0d results: %0d bytes, %0d field ends, %0d record ends, %0d quote errors",
			sb.n_results, sb.n_by_what[WHAT_BYTE], sb.n_by_what[WHAT_FIELD_END],
			sb.n_by_what[WHAT_RECORD_END], sb.n_by_what[WHAT_QUOTE_ERROR]);
		if (sb.errors == 0 && sb.expected_tokens.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

FILE: sim.f
rtl/csvtok_pkg.sv
rtl/csvtok_front.sv
rtl/csvtok_fifo.sv
rtl/csvtok_back.sv
rtl/csv_record_tokenizer.sv
sim/tb.sv
